// ===== rtl/igtv_pkg.sv =====
// ----------------------------------------------------------------------------
// igtv_pkg
// Types, codes and character constants shared by the grid text validator.
// ----------------------------------------------------------------------------
package igtv_pkg;

  localparam int CNT_W = 10;
  localparam logic [CNT_W-1:0] MAX_COLUMNS = 10'd1023;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  typedef enum logic [1:0] {
    SCAN_START = 2'd0,
    SCAN_SPACE = 2'd1,
    SCAN_SIGN  = 2'd2,
    SCAN_DIGIT = 2'd3
  } scan_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_FORMAT = 2'd1,
    ERR_RECT   = 2'd2
  } err_t;

  typedef struct packed {
    scan_t            scan;
    logic [CNT_W-1:0] token_count;
    logic [CNT_W-1:0] first_width;
    logic             width_known;
    err_t             error_code;
  } grid_state_t;

  typedef struct packed {
    err_t             status;
    logic             verdict_ready;
    logic [CNT_W-1:0] line_tokens;
    logic [CNT_W-1:0] row_width;
  } grid_result_t;

  localparam grid_state_t STATE_RESET = '{
    scan:        SCAN_START,
    token_count: '0,
    first_width: '0,
    width_known: 1'b0,
    error_code:  ERR_NONE
  };

endpackage

// ===== rtl/igtv_scan.sv =====
// ----------------------------------------------------------------------------
// igtv_scan
// Next-state and result logic for one text byte or end-of-file request.
// ----------------------------------------------------------------------------
module igtv_scan (
  input  logic [7:0]           text_byte,
  input  logic                 end_of_file,
  input  igtv_pkg::grid_state_t state_cur,
  output igtv_pkg::grid_state_t state_nxt,
  output igtv_pkg::grid_result_t result
);

  igtv_pkg::grid_state_t st;
  logic is_decimal;
  logic is_sign;
  logic is_space;
  logic is_newline;
  logic open_ok;
  logic width_match;

  assign is_decimal = (text_byte >= igtv_pkg::CH_ZERO) && (text_byte <= igtv_pkg::CH_NINE);
  assign is_sign    = (text_byte == igtv_pkg::CH_MINUS) || (text_byte == igtv_pkg::CH_PLUS);
  assign is_space   = (text_byte == igtv_pkg::CH_SPACE);
  assign is_newline = (text_byte == igtv_pkg::CH_NEWLINE);
  assign open_ok    = (state_cur.token_count < igtv_pkg::MAX_COLUMNS);
  assign width_match = (state_cur.token_count == state_cur.first_width);

  always_comb begin
    st = state_cur;
    if (state_cur.error_code == igtv_pkg::ERR_NONE) begin
      if (end_of_file) begin
        if (state_cur.scan == igtv_pkg::SCAN_DIGIT) begin
          if (!state_cur.width_known) begin
            st.first_width = state_cur.token_count;
            st.width_known = 1'b1;
            st.token_count = '0;
            st.scan        = igtv_pkg::SCAN_START;
          end else if (!width_match) begin
            st.error_code = igtv_pkg::ERR_RECT;
          end else begin
            st.token_count = '0;
            st.scan        = igtv_pkg::SCAN_START;
          end
        end else if (state_cur.scan != igtv_pkg::SCAN_START) begin
          st.error_code = igtv_pkg::ERR_FORMAT;
        end
      end else begin
        unique case (state_cur.scan) inside
          igtv_pkg::SCAN_START, igtv_pkg::SCAN_SPACE: begin
            if (is_decimal) begin
              if (open_ok) begin
                st.token_count = state_cur.token_count + 10'd1;
                st.scan        = igtv_pkg::SCAN_DIGIT;
              end else begin
                st.error_code = igtv_pkg::ERR_FORMAT;
              end
            end else if (is_sign) begin
              st.scan = igtv_pkg::SCAN_SIGN;
            end else if (is_space && state_cur.scan == igtv_pkg::SCAN_START) begin
              st.scan = igtv_pkg::SCAN_SPACE;
            end else begin
              st.error_code = igtv_pkg::ERR_FORMAT;
            end
          end
          igtv_pkg::SCAN_SIGN: begin
            if (is_decimal && open_ok) begin
              st.token_count = state_cur.token_count + 10'd1;
              st.scan        = igtv_pkg::SCAN_DIGIT;
            end else begin
              st.error_code = igtv_pkg::ERR_FORMAT;
            end
          end
          igtv_pkg::SCAN_DIGIT: begin
            if (is_decimal) begin
              st.scan = igtv_pkg::SCAN_DIGIT;
            end else if (is_space) begin
              st.scan = igtv_pkg::SCAN_SPACE;
            end else if (is_newline) begin
              if (!state_cur.width_known) begin
                st.first_width = state_cur.token_count;
                st.width_known = 1'b1;
                st.token_count = '0;
                st.scan        = igtv_pkg::SCAN_START;
              end else if (!width_match) begin
                st.error_code = igtv_pkg::ERR_RECT;
              end else begin
                st.token_count = '0;
                st.scan        = igtv_pkg::SCAN_START;
              end
            end else begin
              st.error_code = igtv_pkg::ERR_FORMAT;
            end
          end
          default: st.error_code = igtv_pkg::ERR_FORMAT;
        endcase
      end
    end
  end

  always_comb begin
    result.status        = st.error_code;
    result.verdict_ready = end_of_file;
    result.line_tokens   = st.token_count;
    result.row_width     = st.width_known ? st.first_width : '0;
    state_nxt            = end_of_file ? igtv_pkg::STATE_RESET : st;
  end

endmodule

// ===== rtl/integer_grid_text_validator.sv =====
// ----------------------------------------------------------------------------
// integer_grid_text_validator
// Checks a byte stream for a rectangular grid of signed decimal integers.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; the result is registered
//   from the byte in the input register once the output can advance.
//   Throughput: one byte per cycle while out_tready does not stall the output,
//   with a combinational scan state update between the two registers.
// Reset: rst_n synchronous, active low; clears both stages and the scan state
//   to line start with no tokens, no row width and no error.
module integer_grid_text_validator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [igtv_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] text_byte
  input  logic                            in_tlast,   // end_of_file
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [igtv_pkg::OUT_DATA_W-1:0] out_tdata,  // [1:0] status, [11:2] line_tokens,
                                                      // [21:12] row_width, [23:22] zero
  output logic                            out_tlast   // verdict_ready
);

  logic                   in_valid_r;
  logic [7:0]             in_byte_r;
  logic                   in_eof_r;
  logic                   out_valid_r;
  logic [igtv_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                   out_last_r;
  logic                   advance;
  logic                   fire;
  igtv_pkg::grid_state_t  state_r;
  igtv_pkg::grid_state_t  state_nxt;
  igtv_pkg::grid_result_t result;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  igtv_scan u_scan (
    .text_byte   (in_byte_r),
    .end_of_file (in_eof_r),
    .state_cur   (state_r),
    .state_nxt   (state_nxt),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= igtv_pkg::STATE_RESET;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
      if (fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_eof_r  <= in_tlast;
    end
    if (fire) begin
      out_data_r <= {2'b00, result.row_width, result.line_tokens, result.status};
      out_last_r <= result.verdict_ready;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
